// ===== rtl/core/dvr_pkg.sv =====
package dvr_pkg;

  localparam int VALUE_BITS = 32;
  localparam int OUT_BITS   = 32;
  localparam int CHAR_BITS  = 8;
  localparam int DIGIT_BITS = 5;
  localparam int COUNT_BITS = 3;
  localparam int SHIFT_BITS = 5;

  localparam logic [CHAR_BITS-1:0]  RUN_BASE   = 8'h60;
  localparam logic [CHAR_BITS-1:0]  DATA_MASK  = 8'h1f;
  localparam logic [CHAR_BITS-1:0]  MORE_FLAG  = 8'h20;
  localparam logic [COUNT_BITS-1:0] MAX_DIGITS = 3'd7;

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [DIGIT_BITS-1:0] digit_t;

endpackage

// ===== rtl/core/delta_varint_run_decoder.sv =====
// Channel   Dir  Word             Side info
// s_*       in   s_tdata: char    s_tuser: start_list
// m_*       out  m_tdata: value   m_tlast: last_of_item
//
// Input and output are parted by the result register, so words stream at one
// per cycle while m_tready is high and no run is pending. A run character yields
// (low five bits + 1) results: its extra results come from a down counter,
// and s_tready stays low until the counter is empty.
// Synchronous active-high rst clears the sum, the varint, the run counter and the output valid.
// A stall on m_tready holds the result register and blocks input.
module delta_varint_run_decoder
  import dvr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [CHAR_BITS-1:0] s_tdata,   // [7:0] code_char
  input  logic                 s_tuser,   // [0] start_list
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [OUT_BITS-1:0]  m_tdata,   // [31:0] value
  output logic                 m_tlast    // last_of_item
);

  value_t                total, total_next;
  value_t                partial, partial_next;
  count_t                count, count_next;
  logic [DIGIT_BITS-1:0] run_left, run_left_next;
  logic                  out_valid, out_valid_next;
  logic [OUT_BITS-1:0]   out_value, out_value_next;
  logic                  out_last, out_last_next;

  logic                  slot_free;
  logic                  accept;
  value_t                eff_total, eff_partial;
  count_t                eff_count;
  logic                  is_run;
  digit_t                digit;
  logic [SHIFT_BITS-1:0] shift;
  value_t                new_partial;
  count_t                new_count;
  value_t                sum;

  assign slot_free = !out_valid || m_tready;
  assign s_tready  = (run_left == '0) && slot_free;
  assign accept    = s_tvalid && s_tready;

  assign m_tvalid = out_valid;
  assign m_tdata  = out_value;
  assign m_tlast  = out_last;

  always_comb begin
    eff_total   = s_tuser ? '0 : total;
    eff_partial = s_tuser ? '0 : partial;
    eff_count   = s_tuser ? '0 : count;
    is_run      = (eff_count == '0) && (s_tdata >= RUN_BASE);
    digit       = DIGIT_BITS'(s_tdata & DATA_MASK);
    shift       = {eff_count, 2'b00} + SHIFT_BITS'(eff_count);
    if (eff_count < MAX_DIGITS) begin
      new_partial = eff_partial | (VALUE_BITS'(digit) << shift);
      new_count   = eff_count + 1'b1;
    end else begin
      new_partial = eff_partial;
      new_count   = eff_count;
    end
    sum = eff_total + new_partial + VALUE_BITS'(1);
  end

  always_comb begin
    total_next     = total;
    partial_next   = partial;
    count_next     = count;
    run_left_next  = run_left;
    out_valid_next = out_valid && !m_tready;
    out_value_next = out_value;
    out_last_next  = out_last;
    if (run_left != '0) begin
      if (slot_free) begin
        total_next     = total + VALUE_BITS'(1);
        run_left_next  = run_left - 1'b1;
        out_valid_next = 1'b1;
        out_value_next = OUT_BITS'(total_next);
        out_last_next  = (run_left == DIGIT_BITS'(1));
      end
    end else if (accept) begin
      if (is_run) begin
        total_next     = eff_total + VALUE_BITS'(1);
        partial_next   = eff_partial;
        count_next     = eff_count;
        run_left_next  = digit;
        out_valid_next = 1'b1;
        out_value_next = OUT_BITS'(total_next);
        out_last_next  = (digit == '0);
      end else if ((s_tdata & MORE_FLAG) != '0) begin
        total_next   = eff_total;
        partial_next = new_partial;
        count_next   = new_count;
      end else begin
        total_next     = sum;
        partial_next   = '0;
        count_next     = '0;
        out_valid_next = 1'b1;
        out_value_next = OUT_BITS'(sum);
        out_last_next  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total     <= '0;
      partial   <= '0;
      count     <= '0;
      run_left  <= '0;
      out_valid <= 1'b0;
    end else begin
      total     <= total_next;
      partial   <= partial_next;
      count     <= count_next;
      run_left  <= run_left_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out_value <= out_value_next;
    out_last  <= out_last_next;
  end

  a_run_counter_loaded: assert property (@(posedge clk) disable iff (rst)
    (accept && is_run && digit != '0) |=> (run_left != '0))
    else $error("run counter not loaded for multi-result run");

  a_run_steps_by_one: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=>
      (m_tvalid && m_tdata == $past(m_tdata) + OUT_BITS'(1)))
    else $error("run result does not follow previous by one");

  a_run_has_result: assert property (@(posedge clk) disable iff (rst)
    (run_left != '0) |-> m_tvalid)
    else $error("run pending without a held result");

endmodule

// ===== tb/tb_delta_varint_run_decoder.sv =====
module tb_delta_varint_run_decoder;
  import dvr_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_ITEMS = 66;

  typedef struct packed {
    value_t value;
    logic   last;
  } element_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [CHAR_BITS-1:0] s_tdata = '0;
  logic                 s_tuser = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [OUT_BITS-1:0]  m_tdata;
  logic                 m_tlast;

  element_t elements_due[$];
  value_t   list_sum = '0;
  value_t   delta_acc = '0;
  count_t   digits_taken = '0;

  int gap_pct = 0;
  int stall_pct = 0;
  int hold_request = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  delta_varint_run_decoder DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // hold off the receiver for a requested stretch, otherwise stall at random
  always @(posedge clk) begin : receiver
    int hold_left;
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic report_mismatch(input string what, input value_t got, input value_t want);
    $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    element_t due;
    if (!rst && m_tvalid && m_tready) begin
      if (elements_due.size() == 0) begin
        report_mismatch("unexpected word", m_tdata, '0);
      end else begin
        due = elements_due.pop_front();
        if (m_tdata !== due.value) report_mismatch("value", m_tdata, due.value);
        if (m_tlast !== due.last) report_mismatch("last", value_t'(m_tlast), value_t'(due.last));
      end
    end
  end

  task automatic decode_char(input logic [CHAR_BITS-1:0] ch, input logic start);
    logic [2*VALUE_BITS-1:0] shifted;
    logic [CHAR_BITS-1:0]    extra;
    element_t                el;
    if (start) begin
      list_sum = '0;
      delta_acc = '0;
      digits_taken = '0;
    end
    if (digits_taken == 0 && ch >= RUN_BASE) begin
      extra = ch & DATA_MASK;
      for (int i = 0; i <= extra; i++) begin
        list_sum = list_sum + 1;
        el.value = list_sum;
        el.last = (i == extra);
        elements_due.push_back(el);
      end
    end else begin
      if (digits_taken < MAX_DIGITS) begin
        shifted = (2*VALUE_BITS)'(ch & DATA_MASK) << (DIGIT_BITS * digits_taken);
        delta_acc = delta_acc | shifted[VALUE_BITS-1:0];
        digits_taken = digits_taken + 1'b1;
      end
      if ((ch & MORE_FLAG) == 0) begin
        list_sum = list_sum + delta_acc + 1;
        delta_acc = '0;
        digits_taken = '0;
        el.value = list_sum;
        el.last = 1'b1;
        elements_due.push_back(el);
      end
    end
  endtask

  task automatic send_char(input logic [CHAR_BITS-1:0] ch, input logic start);
    while ($urandom_range(99) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= ch;
    s_tuser <= start;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    decode_char(ch, start);
  endtask

  task automatic test_runs;
    send_char(8'h60, 1'b0);
    send_char(8'h7f, 1'b0);
    send_char(8'hff, 1'b0);
    send_char(8'h80, 1'b0);
  endtask

  task automatic test_single_digits;
    send_char(8'h01, 1'b0);
    send_char(8'h00, 1'b0);
    send_char(8'h5f, 1'b0);
  endtask

  task automatic test_varints;
    send_char(8'h3f, 1'b0);
    send_char(8'h3f, 1'b0);
    send_char(8'h1f, 1'b0);
    // run-range characters act as digits once a varint is open
    send_char(8'h21, 1'b0);
    send_char(8'he5, 1'b0);
    send_char(8'h9f, 1'b0);
  endtask

  task automatic test_long_varint;
    for (int i = 0; i < 8; i++) send_char(8'h3f, 1'b0);
    send_char(8'h1f, 1'b0);
  endtask

  task automatic test_start_list;
    send_char(8'h25, 1'b0);
    send_char(8'h61, 1'b1);
    send_char(8'h3a, 1'b0);
    send_char(8'h07, 1'b1);
  endtask

  task automatic send_varint(input int digits, input logic start);
    logic [CHAR_BITS-1:0] ch;
    for (int i = 0; i < digits; i++) begin
      ch = CHAR_BITS'($urandom_range(255));
      ch = (ch & ~MORE_FLAG) | ((i < digits - 1) ? MORE_FLAG : 8'h00);
      if (i == 0) ch[7] = 1'b0;
      if (i == 0 && ch[5]) ch[6] = 1'b0;
      send_char(ch, start && i == 0);
    end
  endtask

  task automatic test_random(input int gaps, input int stalls, input int items);
    int sent;
    int digits;
    int pick;
    gap_pct = gaps;
    stall_pct = stalls;
    sent = 0;
    while (sent < items) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        digits = ($urandom_range(9) == 0) ? $urandom_range(5, 9) : $urandom_range(1, 4);
        send_varint(digits, $urandom_range(19) == 0);
        sent += digits;
      end else if (pick < 70) begin
        send_char(CHAR_BITS'($urandom_range(8'h60, 8'hff)), 1'b0);
        sent++;
      end else if (pick < 80) begin
        send_char(CHAR_BITS'($urandom_range(1, 255)), 1'b1);
        sent++;
      end else begin
        send_char(CHAR_BITS'($urandom_range(1, 255)), $urandom_range(19) == 0);
        sent++;
      end
    end
  endtask

  task automatic test_backpressure;
    gap_pct = 0;
    stall_pct = 0;
    hold_request = 300;
    for (int i = 0; i < 12; i++) begin
      if (i % 3 == 0) send_char(CHAR_BITS'($urandom_range(8'h60, 8'hff)), 1'b0);
      else send_varint(1, 1'b0);
    end
  endtask

  task automatic wait_drained;
    while (elements_due.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_runs();
    test_single_digits();
    test_varints();
    test_long_varint();
    test_start_list();
    test_random(0, 0, RANDOM_ITEMS);
    test_random(53, 0, RANDOM_ITEMS);
    test_random(0, 53, RANDOM_ITEMS);
    test_random(36, 36, RANDOM_ITEMS);
    test_backpressure();
    s_tvalid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && elements_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
